### hdl/srme_pkg.sv
// Shared types, codes and constants of the sound register to MIDI translator.
// The note table contents are built here at elaboration from the pitch formula.
// No dependencies.
`default_nettype none

package srme_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int ROM_DEPTH    = 2048;
    localparam int ROM_AW       = 11;
    localparam int STEP_W       = 3;

    localparam logic [4:0]  DELTA_SHIFT_RESET = 5'd14;

    // commands
    localparam logic [1:0]  CMD_WRITE  = 2'd0;
    localparam logic [1:0]  CMD_UPDATE = 2'd1;
    localparam logic [1:0]  CMD_FLUSH  = 2'd2;

    // sound register addresses
    localparam logic [15:0] ADDR_VOL0  = 16'hff12;
    localparam logic [15:0] ADDR_VOL1  = 16'hff17;
    localparam logic [15:0] ADDR_VOL2  = 16'hff1c;
    localparam logic [15:0] ADDR_TRIG0 = 16'hff14;
    localparam logic [15:0] ADDR_TRIG1 = 16'hff19;
    localparam logic [15:0] ADDR_TRIG2 = 16'hff1e;
    localparam logic [15:0] ADDR_PAN   = 16'hff25;

    // MIDI codes
    localparam logic [7:0]  ST_NOTE_ON  = 8'h90;
    localparam logic [7:0]  ST_NOTE_OFF = 8'h80;
    localparam logic [7:0]  ST_CONTROL  = 8'hb0;
    localparam logic [7:0]  ST_META     = 8'hff;
    localparam logic [6:0]  CTRL_PAN    = 7'h0a;
    localparam logic [6:0]  META_EOT    = 7'h2f;
    localparam logic [6:0]  PAN_LEFT    = 7'd0;
    localparam logic [6:0]  PAN_RIGHT   = 7'd127;
    localparam logic [6:0]  PAN_CENTER  = 7'd64;

    localparam logic [63:0] FIFTH_Q52 = 64'd900719925474099;
    localparam logic [31:0] CLOCK_REF = 32'd262144;

    typedef logic [7:0] note_rom_t [ROM_DEPTH];

    // (a*b) >> 62, kept to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // log2 in Q52 by repeated squaring of a Q62 mantissa
    function automatic logic [63:0] log2_q52(input logic [31:0] v);
        logic [5:0]  e;
        logic [63:0] x;
        logic [63:0] frac;
        e    = 6'd0;
        frac = 64'd0;
        for (int i = 0; i < 31; i++) begin
            if ((v >> (i + 1)) != 32'd0) begin
                e = 6'(i + 1);
            end
        end
        x = {32'd0, v} << (6'd62 - e);
        for (int i = 0; i < 52; i++) begin
            x    = mul_q62(x, x);
            frac = frac << 1;
            if (x[63]) begin
                x    = x >> 1;
                frac = frac | 64'd1;
            end
        end
        return ({58'd0, e} << 52) | frac;
    endfunction

    function automatic note_rom_t build_rom();
        note_rom_t   rom;
        logic [63:0] base;
        logic [31:0] f;
        logic [63:0] v;
        base = log2_q52(32'd55);
        for (int d = 1; d <= ROM_DEPTH; d++) begin
            f = CLOCK_REF / 32'(d);
            v = 64'd12 * (log2_q52(f) - base) + FIFTH_Q52;
            rom[d - 1] = 8'((v >> 52) + 64'd21);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

### hdl/srme_if.sv
// Valid/ready channel interfaces for input events and MIDI events.
// Depends on nothing.
`default_nettype none

interface srme_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [47:0] cycle_time;
    logic [15:0] reg_addr;
    logic [7:0]  reg_value;
    logic [1:0]  channel_index;
    logic        running;
    logic        master_on;
    logic [3:0]  envelope_level;
    logic [11:0] divider;

    modport source (output valid, cmd, cycle_time, reg_addr, reg_value, channel_index,
                    running, master_on, envelope_level, divider, input ready);
    modport sink   (input valid, cmd, cycle_time, reg_addr, reg_value, channel_index,
                    running, master_on, envelope_level, divider, output ready);
endinterface

interface srme_out_if;
    logic        valid;
    logic        ready;
    logic [27:0] delta_ticks;
    logic [7:0]  status_byte;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic        last_of_run;

    modport source (output valid, delta_ticks, status_byte, data_first, data_second,
                    last_of_run, input ready);
    modport sink   (input valid, delta_ticks, status_byte, data_first, data_second,
                    last_of_run, output ready);
endinterface

`default_nettype wire

### hdl/srme_note_rom.sv
// Divider to note number ROM with registered read.
// Depends on srme_pkg (table contents built at elaboration).
`default_nettype none

module srme_note_rom
    import srme_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ROM_AW-1:0] rd_addr,
    output logic [7:0]             rd_data
);

    localparam note_rom_t NOTE_ROM = build_rom();

    // synchronous read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= NOTE_ROM[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/sound_register_to_midi_events.sv
// Top level: sound chip events in, MIDI channel events out.
// Depends on srme_pkg, srme_if (srme_in_if, srme_out_if) and srme_note_rom.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    cmd, cycle_time, reg_addr, reg_value, channel ...
//   out_ch    out   valid/ready    delta_ticks, status_byte, data_first, ...
//   cfg       in    cfg_we         cfg_wdata = delta_shift
//
// An accepted event in is worked off in one sequencer step per possible
// MIDI event: channel update 2, pan write NUM_CHANNELS, flush NUM_CHANNELS+1,
// any other item 1. The input is ready again the cycle after the last step.
// The single delta unit (48-bit subtract and shift) serves one event a step.
// A step with an event waits while the output register is full and not taken.
// Reset clears all notes, velocities, active flags and time; delta_shift is 14.
`default_nettype none

module sound_register_to_midi_events
    import srme_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    srme_in_if.sink         in_ch,
    srme_out_if.source      out_ch
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN} state_t;
    typedef enum logic [2:0] {K_NONE, K_TRIG, K_PAN, K_UPD, K_FLUSH} kind_t;

    state_t            state_reg;
    kind_t             kind_reg;
    logic [STEP_W-1:0] step_reg;
    logic [47:0]       t_reg;
    logic [7:0]        val_reg;
    logic [1:0]        ch_reg;
    logic              play_reg;
    logic              div_ok_reg;
    logic              upd_on_reg;
    logic [6:0]        nn_reg;
    logic [6:0]        note_reg [4];
    logic [6:0]        vel_reg [4];
    logic              active_reg [4];
    logic [47:0]       last_reg;
    logic [4:0]        shift_reg;

    logic        out_valid_reg;
    logic [27:0] out_delta_reg;
    logic [7:0]  out_status_reg;
    logic [6:0]  out_d1_reg;
    logic [6:0]  out_d2_reg;
    logic        out_last_reg;

    logic [7:0]  rom_q;
    logic        in_acc;
    logic        slot_free;

    // current step event
    logic        ev_en;
    logic        ev_last;
    logic        ev_final;
    logic [47:0] ev_time;
    logic [7:0]  ev_status;
    logic [6:0]  ev_d1;
    logic [6:0]  ev_d2;
    logic [1:0]  ev_ch;
    logic        ev_clr_note;
    logic        ev_set_note;
    logic        emit;
    logic        go;

    // channel update plan, valid at step 0
    logic [7:0]  nn8;
    logic        nn_ok;
    logic        plan_off;
    logic        plan_on;
    logic        plan_set_act;
    logic        plan_clr_act;

    logic [47:0] diff;
    logic [47:0] shifted;

    assign in_acc       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign slot_free    = !out_valid_reg || out_ch.ready;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.delta_ticks = out_delta_reg;
    assign out_ch.status_byte = out_status_reg;
    assign out_ch.data_first  = out_d1_reg;
    assign out_ch.data_second = out_d2_reg;
    assign out_ch.last_of_run = out_last_reg;

    srme_note_rom u_rom (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (ROM_AW'(in_ch.divider - 12'd1)),
        .rd_data (rom_q)
    );

    // note decision for a channel update
    always_comb
    begin
        nn8          = div_ok_reg ? rom_q : 8'd128;
        nn_ok        = !nn8[7];
        plan_off     = 1'b0;
        plan_on      = 1'b0;
        plan_set_act = 1'b0;
        plan_clr_act = 1'b0;
        if (active_reg[ch_reg])
        begin
            if (play_reg)
            begin
                if (nn8 != {1'b0, note_reg[ch_reg]})
                begin
                    plan_off = (note_reg[ch_reg] != 7'd0);
                    plan_on  = nn_ok;
                end
            end
            else
            begin
                plan_off     = (note_reg[ch_reg] != 7'd0);
                plan_clr_act = 1'b1;
            end
        end
        else if (play_reg && nn_ok)
        begin
            plan_on      = 1'b1;
            plan_set_act = 1'b1;
        end
    end

    // event of the current step
    always_comb
    begin
        ev_en       = 1'b0;
        ev_last     = 1'b0;
        ev_final    = 1'b1;
        ev_time     = t_reg;
        ev_status   = ST_NOTE_OFF;
        ev_d1       = 7'd0;
        ev_d2       = 7'd0;
        ev_ch       = ch_reg;
        ev_clr_note = 1'b0;
        ev_set_note = 1'b0;
        case (kind_reg)
            K_TRIG:
            begin
                ev_en       = (note_reg[ch_reg] != 7'd0);
                ev_last     = 1'b1;
                ev_status   = ST_NOTE_OFF | {6'd0, ch_reg};
                ev_d1       = note_reg[ch_reg];
                ev_clr_note = 1'b1;
            end
            K_PAN:
            begin
                ev_ch     = step_reg[1:0];
                ev_en     = 1'b1;
                ev_final  = (step_reg == STEP_W'(NUM_CHANNELS - 1));
                ev_last   = ev_final;
                ev_status = ST_CONTROL | {6'd0, ev_ch};
                ev_d1     = CTRL_PAN;
                case ({val_reg[3'd4 + {1'b0, ev_ch}], val_reg[ev_ch]})
                    2'b10:   ev_d2 = PAN_LEFT;
                    2'b01:   ev_d2 = PAN_RIGHT;
                    default: ev_d2 = PAN_CENTER;
                endcase
            end
            K_UPD:
            begin
                ev_final = (step_reg != STEP_W'(0));
                if (step_reg == STEP_W'(0))
                begin
                    ev_en       = plan_off;
                    ev_last     = !plan_on;
                    ev_status   = ST_NOTE_OFF | {6'd0, ch_reg};
                    ev_d1       = note_reg[ch_reg];
                    ev_clr_note = 1'b1;
                end
                else
                begin
                    ev_en       = upd_on_reg;
                    ev_last     = 1'b1;
                    ev_status   = ST_NOTE_ON | {6'd0, ch_reg};
                    ev_d1       = nn_reg;
                    ev_d2       = vel_reg[ch_reg];
                    ev_set_note = 1'b1;
                end
            end
            K_FLUSH:
            begin
                ev_final = (step_reg == STEP_W'(NUM_CHANNELS));
                if (ev_final)
                begin
                    ev_en     = 1'b1;
                    ev_last   = 1'b1;
                    ev_time   = last_reg;
                    ev_status = ST_META;
                    ev_d1     = META_EOT;
                end
                else
                begin
                    ev_ch       = step_reg[1:0];
                    ev_en       = (note_reg[ev_ch] != 7'd0);
                    ev_time     = last_reg + 48'd1;
                    ev_status   = ST_NOTE_OFF | {6'd0, ev_ch};
                    ev_d1       = note_reg[ev_ch];
                    ev_clr_note = 1'b1;
                end
            end
            default:
            begin
                ev_en = 1'b0;
            end
        endcase
    end

    assign emit = (state_reg == ST_RUN) && ev_en && slot_free;
    assign go   = (state_reg == ST_RUN) && (!ev_en || slot_free);

    // shared delta unit
    assign diff    = ev_time - last_reg;
    assign shifted = diff >> shift_reg;

    // sequencer, channel state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= K_NONE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
            shift_reg     <= DELTA_SHIFT_RESET;
            upd_on_reg    <= 1'b0;
            for (int c = 0; c < 4; c++)
            begin
                note_reg[c]   <= '0;
                vel_reg[c]    <= '0;
                active_reg[c] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                shift_reg <= cfg_wdata;
            end

            if (out_valid_reg && out_ch.ready && !emit)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= '0;
                        kind_reg  <= K_NONE;
                        case (in_ch.cmd)
                            CMD_WRITE:
                            begin
                                case (in_ch.reg_addr)
                                    ADDR_VOL0:
                                        vel_reg[0] <= {in_ch.reg_value[7:4], 3'd0};
                                    ADDR_VOL1:
                                        vel_reg[1] <= {in_ch.reg_value[7:4], 3'd0};
                                    ADDR_VOL2:
                                        vel_reg[2] <= {2'(3'd4 - in_ch.reg_value[7:5]), 5'd0};
                                    ADDR_TRIG0, ADDR_TRIG1, ADDR_TRIG2:
                                    begin
                                        if (in_ch.reg_value[7])
                                        begin
                                            kind_reg <= K_TRIG;
                                            case (in_ch.reg_addr)
                                                ADDR_TRIG0:
                                                    active_reg[0] <= 1'b0;
                                                ADDR_TRIG1:
                                                    active_reg[1] <= 1'b0;
                                                default:
                                                    active_reg[2] <= 1'b0;
                                            endcase
                                        end
                                    end
                                    ADDR_PAN:
                                        kind_reg <= K_PAN;
                                    default:
                                        kind_reg <= K_NONE;
                                endcase
                            end
                            CMD_UPDATE:
                            begin
                                if (in_ch.channel_index != 2'd3)
                                begin
                                    kind_reg <= K_UPD;
                                end
                            end
                            CMD_FLUSH:
                                kind_reg <= K_FLUSH;
                            default:
                                kind_reg <= K_NONE;
                        endcase
                    end
                end
                ST_RUN:
                begin
                    // channel update bookkeeping at its first step
                    if (go && kind_reg == K_UPD && step_reg == STEP_W'(0))
                    begin
                        upd_on_reg <= plan_on;
                        nn_reg     <= nn8[6:0];
                        if (plan_set_act)
                        begin
                            active_reg[ch_reg] <= 1'b1;
                        end
                        if (plan_clr_act)
                        begin
                            active_reg[ch_reg] <= 1'b0;
                        end
                    end

                    // end of track restarts time for the next track
                    if (emit)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_delta_reg  <= shifted[27:0];
                        out_status_reg <= ev_status;
                        out_d1_reg     <= ev_d1;
                        out_d2_reg     <= ev_d2;
                        out_last_reg   <= ev_last;
                        last_reg       <= (kind_reg == K_FLUSH && ev_final) ? '0 : ev_time;
                        if (ev_clr_note)
                        begin
                            note_reg[ev_ch] <= 7'd0;
                        end
                        if (ev_set_note)
                        begin
                            note_reg[ev_ch] <= ev_d1;
                        end
                    end

                    if (go)
                    begin
                        if (ev_final)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            step_reg <= step_reg + STEP_W'(1);
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // captured item payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            t_reg      <= in_ch.cycle_time;
            val_reg    <= in_ch.reg_value;
            play_reg   <= in_ch.running && in_ch.master_on && (in_ch.envelope_level != 4'd0);
            div_ok_reg <= (in_ch.divider != 12'd0) && (in_ch.divider <= 12'(ROM_DEPTH));
            if (in_ch.cmd == CMD_UPDATE)
            begin
                ch_reg <= in_ch.channel_index;
            end
            else
            begin
                case (in_ch.reg_addr)
                    ADDR_TRIG0: ch_reg <= 2'd0;
                    ADDR_TRIG1: ch_reg <= 2'd1;
                    default:    ch_reg <= 2'd2;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ch.ready)
        else $error("input taken again while an item is in work");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !emit)
        else $error("event produced without an item in work");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(NUM_CHANNELS))
        else $error("sequencer step out of range");

    a_eot_clears_time: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && ev_status == ST_META) |=> (last_reg == 48'd0))
        else $error("end of track did not restart time");
`endif

endmodule

`default_nettype wire

### verif/sound_register_to_midi_events_tb.sv
// Testbench for sound_register_to_midi_events: directed rows, then random events.
// A local model of the translator predicts every MIDI event and checks it.
// Depends on srme_pkg and srme_if (srme_in_if, srme_out_if).
`default_nettype none

module sound_register_to_midi_events_tb;
    import srme_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] cycle_time;
        logic [15:0] reg_addr;
        logic [7:0]  reg_value;
        logic [1:0]  channel_index;
        logic        running;
        logic        master_on;
        logic [3:0]  envelope_level;
        logic [11:0] divider;
    } sound_event_t;

    typedef struct packed {
        logic [27:0] delta_ticks;
        logic [7:0]  status_byte;
        logic [6:0]  data_first;
        logic [6:0]  data_second;
        logic        last_of_run;
    } midi_event_t;

    // directed row: event plus a count and first status where obvious
    typedef struct {
        sound_event_t ev;
        bit           known;
        int           n_events;
        logic [7:0]   first_status;
    } stim_row_t;

    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam int         IDLE_LIMIT  = 4000;
    localparam int         DRAIN_WAIT  = 12;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_wdata;

    srme_in_if  in_ch ();
    srme_out_if out_ch ();

    sound_register_to_midi_events u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // predictor state
    logic [7:0]  pitch_rom [ROM_DEPTH];
    logic [6:0]  cur_note [4];
    logic [6:0]  velocity [4];
    logic        active_ch [4];
    logic [47:0] last_time;
    logic [4:0]  tick_shift;

    midi_event_t midi_expected [$];
    stim_row_t   dir_rows [$];

    int  errors;
    int  events_sent;
    int  events_checked;
    int  idle_cycles;
    bit  sink_steady;
    bit  src_steady;

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Q62 square step: (a*b) >> 62
    function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        return prod[125:62];
    endfunction

    function automatic logic [63:0] pitch_log2(logic [31:0] v);
        int          e;
        logic [63:0] x;
        logic [63:0] frac;
        e = 0;
        frac = '0;
        while (e < 31 && (v >> (e + 1)) != 0)
            e++;
        x = 64'(v) << (62 - e);
        for (int i = 0; i < 52; i++)
        begin
            x = q62_mul(x, x);
            frac = frac << 1;
            if (x[63])
            begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(e) << 52) | frac;
    endfunction

    function automatic void fill_pitch_rom();
        logic [63:0] base;
        logic [63:0] v;
        base = pitch_log2(32'd55);
        for (int d = 1; d <= ROM_DEPTH; d++)
        begin
            v = 64'd12 * (pitch_log2(32'd262144 / 32'(d)) - base) + FIFTH_Q52;
            pitch_rom[d - 1] = 8'((v >> 52) + 64'd21);
        end
    endfunction

    function automatic void push_midi(logic [47:0] t, logic [7:0] st, logic [6:0] d1,
                                      logic [6:0] d2);
        midi_event_t m;
        m.delta_ticks = 28'((t - last_time) >> tick_shift);
        m.status_byte = st;
        m.data_first = d1;
        m.data_second = d2;
        m.last_of_run = 1'b0;
        last_time = t;
        midi_expected.push_back(m);
    endfunction

    function automatic void release_note(logic [47:0] t, int c);
        if (cur_note[c] != 0)
        begin
            push_midi(t, ST_NOTE_OFF | 8'(c), cur_note[c], 7'd0);
            cur_note[c] = '0;
        end
    endfunction

    function automatic void strike_note(logic [47:0] t, int c, int nn);
        push_midi(t, ST_NOTE_ON | 8'(c), 7'(nn), velocity[c]);
        cur_note[c] = 7'(nn);
    endfunction

    // predicts the MIDI events of one accepted sound event, returns their count
    function automatic int translate_event(sound_event_t ev);
        int  first;
        int  c;
        int  nn;
        bit  play;
        logic [6:0] pan;
        logic [7:0] bits;
        first = midi_expected.size();
        if (ev.cmd == CMD_WRITE)
        begin
            case (ev.reg_addr)
                ADDR_VOL0: velocity[0] = 7'(8 * (ev.reg_value >> 4));
                ADDR_VOL1: velocity[1] = 7'(8 * (ev.reg_value >> 4));
                ADDR_VOL2: velocity[2] = 7'(32 * ((4 - (ev.reg_value >> 5)) & 3));
                ADDR_TRIG0, ADDR_TRIG1, ADDR_TRIG2:
                    if (ev.reg_value[7])
                    begin
                        c = (ev.reg_addr - 16'hff10) / 5;
                        release_note(ev.cycle_time, c);
                        active_ch[c] = 1'b0;
                    end
                ADDR_PAN:
                    for (c = 0; c < NUM_CHANNELS; c++)
                    begin
                        bits = (ev.reg_value >> c) & 8'h11;
                        pan = bits == 8'h10 ? PAN_LEFT : bits == 8'h01 ? PAN_RIGHT
                                                                       : PAN_CENTER;
                        push_midi(ev.cycle_time, ST_CONTROL | 8'(c), CTRL_PAN, pan);
                    end
                default: ;
            endcase
        end
        else if (ev.cmd == CMD_UPDATE && ev.channel_index < 3)
        begin
            c = ev.channel_index;
            play = ev.running && ev.master_on && ev.envelope_level != 0;
            nn = 128;
            if (ev.divider >= 1 && ev.divider <= ROM_DEPTH)
                nn = pitch_rom[ev.divider - 1];
            if (active_ch[c])
            begin
                if (!play)
                begin
                    release_note(ev.cycle_time, c);
                    active_ch[c] = 1'b0;
                end
                else if (nn != cur_note[c])
                begin
                    release_note(ev.cycle_time, c);
                    if (nn < 128)
                        strike_note(ev.cycle_time, c, nn);
                end
            end
            else if (play && nn < 128)
            begin
                strike_note(ev.cycle_time, c, nn);
                active_ch[c] = 1'b1;
            end
        end
        else if (ev.cmd == CMD_FLUSH)
        begin
            for (c = 0; c < NUM_CHANNELS; c++)
                release_note(last_time + 48'd1, c);
            push_midi(last_time, ST_META, META_EOT, 7'd0);
            last_time = '0;
        end
        if (midi_expected.size() > first)
            midi_expected[midi_expected.size() - 1].last_of_run = 1'b1;
        return midi_expected.size() - first;
    endfunction

    function automatic sound_event_t mk_ev(logic [1:0] cmd, logic [47:0] t,
                                           logic [15:0] addr, logic [7:0] val,
                                           logic [1:0] ch, logic run, logic mst,
                                           logic [3:0] env, logic [11:0] div);
        sound_event_t ev;
        ev = '{cmd, t, addr, val, ch, run, mst, env, div};
        return ev;
    endfunction

    function automatic void add_row(sound_event_t ev, bit known = 0, int n = 0,
                                    logic [7:0] st = 8'h00);
        stim_row_t r;
        r.ev = ev;
        r.known = known;
        r.n_events = n;
        r.first_status = st;
        dir_rows.push_back(r);
    endfunction

    // random event, mostly well-formed traffic on the three tone channels
    function automatic sound_event_t rand_event(ref logic [47:0] t_now);
        sound_event_t ev;
        logic [95:0]  rnd;
        int pick;
        rnd = {$urandom, $urandom, $urandom};
        ev = rnd[93:0];
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3)
            t_now = {16'($urandom), 32'($urandom)};
        else
            t_now = t_now + 48'($urandom_range(0, 1 << 22));
        ev.cycle_time = t_now;
        if (pick < 50)
        begin
            ev.cmd = CMD_UPDATE;
            ev.channel_index = 2'($urandom_range(0, 2));
            ev.running = $urandom_range(0, 9) != 0;
            ev.master_on = $urandom_range(0, 9) != 0;
            if ($urandom_range(0, 4) == 0)
                ev.envelope_level = '0;
            case ($urandom_range(0, 19))
                0: ev.divider = '0;
                1: ev.divider = 12'($urandom_range(ROM_DEPTH + 1, 4095));
                2, 3, 4, 5: ev.divider = 12'($urandom_range(1, 16));
                default: ev.divider = 12'($urandom_range(1, ROM_DEPTH));
            endcase
        end
        else if (pick < 65)
        begin
            ev.cmd = CMD_WRITE;
            case ($urandom_range(0, 2))
                0: ev.reg_addr = ADDR_VOL0;
                1: ev.reg_addr = ADDR_VOL1;
                default: ev.reg_addr = ADDR_VOL2;
            endcase
        end
        else if (pick < 75)
        begin
            ev.cmd = CMD_WRITE;
            case ($urandom_range(0, 2))
                0: ev.reg_addr = ADDR_TRIG0;
                1: ev.reg_addr = ADDR_TRIG1;
                default: ev.reg_addr = ADDR_TRIG2;
            endcase
        end
        else if (pick < 82)
        begin
            ev.cmd = CMD_WRITE;
            ev.reg_addr = ADDR_PAN;
        end
        else if (pick < 87)
            ev.cmd = CMD_FLUSH;
        else if (pick < 92)
            ev.cmd = CMD_WRITE;
        else if (pick < 95)
            ev.cmd = CMD_NONE;
        return ev;
    endfunction

    // one input transfer; prediction runs when it is accepted
    task automatic send_event(sound_event_t ev, output int n);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.cmd, in_ch.cycle_time, in_ch.reg_addr, in_ch.reg_value,
         in_ch.channel_index, in_ch.running, in_ch.master_on,
         in_ch.envelope_level, in_ch.divider} <= ev;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n = translate_event(ev);
        events_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (midi_expected.size() != 0)
            @(posedge clk);
    endtask

    // register write only with the block idle
    task automatic set_tick_shift(logic [4:0] v);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tick_shift = v;
    endtask

    task automatic run_random(int count, ref logic [47:0] t_now);
        int n;
        for (int i = 0; i < count; i++)
        begin
            if (i % 20 == 0)
                src_steady = $urandom_range(0, 3) == 0;
            send_event(rand_event(t_now), n);
        end
    endtask

    // output side stalls
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        sink_steady = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // compare each output transfer with the oldest prediction
    always @(posedge clk)
    begin
        midi_event_t got;
        midi_event_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.delta_ticks, out_ch.status_byte, out_ch.data_first,
                    out_ch.data_second, out_ch.last_of_run};
            if (midi_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected MIDI event %h", $time, got);
            end
            else
            begin
                want = midi_expected.pop_front();
                events_checked++;
                if (got.delta_ticks != want.delta_ticks)
                    $display("%0t: delta_ticks expected %0d actual %0d", $time,
                             want.delta_ticks, got.delta_ticks);
                if (got.status_byte != want.status_byte)
                    $display("%0t: status_byte expected %h actual %h", $time,
                             want.status_byte, got.status_byte);
                if (got.data_first != want.data_first)
                    $display("%0t: data_first expected %h actual %h", $time,
                             want.data_first, got.data_first);
                if (got.data_second != want.data_second)
                    $display("%0t: data_second expected %h actual %h", $time,
                             want.data_second, got.data_second);
                if (got.last_of_run != want.last_of_run)
                    $display("%0t: last_of_run expected %b actual %b", $time,
                             want.last_of_run, got.last_of_run);
                if (got != want)
                    errors++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("sound_register_to_midi_events verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus
    initial
    begin
        logic [47:0] t_now;
        int n;
        errors = 0;
        events_sent = 0;
        events_checked = 0;
        idle_cycles = 0;
        src_steady = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        {in_ch.cmd, in_ch.cycle_time, in_ch.reg_addr, in_ch.reg_value, in_ch.channel_index,
         in_ch.running, in_ch.master_on, in_ch.envelope_level, in_ch.divider} = '0;
        for (int c = 0; c < 4; c++)
        begin
            cur_note[c] = '0;
            velocity[c] = '0;
            active_ch[c] = 1'b0;
        end
        last_time = '0;
        tick_shift = DELTA_SHIFT_RESET;
        fill_pitch_rom();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset shift
        add_row(mk_ev(CMD_FLUSH, 48'd5, 0, 0, 0, 0, 0, 0, 0), 1, 1, ST_META);
        add_row(mk_ev(CMD_NONE, '1, '1, '1, '1, 1, 1, '1, '1), 1, 0);
        add_row(mk_ev(CMD_WRITE, 48'd100, ADDR_VOL0, 8'hf0, 0, 0, 0, 0, 0), 1, 0);
        add_row(mk_ev(CMD_WRITE, 48'd200, ADDR_VOL1, 8'hff, 0, 0, 0, 0, 0), 1, 0);
        add_row(mk_ev(CMD_WRITE, 48'd300, ADDR_VOL2, 8'h00, 0, 0, 0, 0, 0), 1, 0);
        add_row(mk_ev(CMD_UPDATE, 48'h10000, 0, 0, 0, 1, 1, 4'hf, 12'd2048));
        add_row(mk_ev(CMD_UPDATE, 48'h20000, 0, 0, 1, 1, 1, 4'h1, 12'd1000));
        add_row(mk_ev(CMD_UPDATE, 48'h30000, 0, 0, 2, 1, 1, 4'h8, 12'd1));
        add_row(mk_ev(CMD_UPDATE, 48'h30000, 0, 0, 2, 1, 1, 4'h8, 12'd500));
        add_row(mk_ev(CMD_UPDATE, 48'h40000, 0, 0, 3, 1, 1, 4'hf, 12'd100), 1, 0);
        add_row(mk_ev(CMD_WRITE, 48'h50000, ADDR_PAN, 8'h10, 0, 0, 0, 0, 0), 1, 4,
                ST_CONTROL);
        add_row(mk_ev(CMD_WRITE, 48'h50001, ADDR_PAN, 8'h01, 0, 0, 0, 0, 0), 1, 4,
                ST_CONTROL);
        add_row(mk_ev(CMD_WRITE, 48'h50002, ADDR_PAN, 8'hff, 0, 0, 0, 0, 0), 1, 4,
                ST_CONTROL);
        add_row(mk_ev(CMD_WRITE, 48'h50003, ADDR_PAN, 8'h00, 0, 0, 0, 0, 0), 1, 4,
                ST_CONTROL);
        add_row(mk_ev(CMD_UPDATE, 48'h60000, 0, 0, 0, 1, 1, 4'hf, 12'd300));
        add_row(mk_ev(CMD_UPDATE, 48'h70000, 0, 0, 0, 1, 1, 4'h0, 12'd300));
        add_row(mk_ev(CMD_UPDATE, 48'h80000, 0, 0, 1, 1, 1, 4'hf, 12'd0));
        add_row(mk_ev(CMD_UPDATE, 48'h90000, 0, 0, 1, 1, 0, 4'hf, 12'd4095));
        add_row(mk_ev(CMD_WRITE, 48'ha0000, ADDR_TRIG2, 8'h80, 0, 0, 0, 0, 0));
        add_row(mk_ev(CMD_WRITE, 48'ha0001, ADDR_TRIG1, 8'h7f, 0, 0, 0, 0, 0));
        add_row(mk_ev(CMD_WRITE, 48'hb0000, 16'hffff, 8'h55, 0, 0, 0, 0, 0), 1, 0);
        add_row(mk_ev(CMD_UPDATE, 48'hffff_ffff_ffff, 0, 0, 0, 1, 1, 4'hf, 12'd40));
        add_row(mk_ev(CMD_FLUSH, 48'd0, 0, 0, 0, 0, 0, 0, 0));

        foreach (dir_rows[i])
        begin
            n = midi_expected.size();
            send_event(dir_rows[i].ev, n);
            if (dir_rows[i].known && (n != dir_rows[i].n_events || (n > 0 &&
                midi_expected[midi_expected.size() - n].status_byte !=
                dir_rows[i].first_status)))
            begin
                errors++;
                $display("%0t: row %0d expected %0d events status %h, predicted %0d",
                         $time, i, dir_rows[i].n_events, dir_rows[i].first_status, n);
            end
        end

        // random phases across shift settings
        t_now = '0;
        set_tick_shift(DELTA_SHIFT_RESET);
        run_random(60, t_now);
        set_tick_shift(5'd0);
        run_random(30, t_now);
        wait_drained();
        run_random(30, t_now);
        set_tick_shift(5'd31);
        run_random(60, t_now);
        set_tick_shift(5'($urandom_range(1, 30)));
        run_random(60, t_now);

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Sent %0d sound events, checked %0d MIDI events over four tick shifts.",
                 events_sent, events_checked);
        if (errors == 0)
            $display("sound_register_to_midi_events verification clean");
        else
            $display("sound_register_to_midi_events verification failed");
        $finish;
    end

endmodule

`default_nettype wire
